/* rtl/core/hsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants of the scaled HMM forward step.
// ----------------------------------------------------------------------------
package hsf_pkg;

    localparam int DEF_STATES   = 16;
    localparam int DEF_CHANNELS = 4;
    localparam int DEF_SYMBOLS  = 32;

    // At most this many states produce results per observation.
    localparam int MAX_OUT = 16;

    localparam int PROB_W = 32;
    // Sum of up to MAX_OUT values below 2^32.
    localparam int SUM_W  = 36;
    localparam int WIDE_W = 64;

    localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd1;

    localparam logic [2:0] CMD_WR_TRANS   = 3'd0;
    localparam logic [2:0] CMD_WR_EMIT    = 3'd1;
    localparam logic [2:0] CMD_WR_INIT    = 3'd2;
    localparam logic [2:0] CMD_OBS_FIRST  = 3'd3;
    localparam logic [2:0] CMD_OBS_NEXT   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_TRANS,
        ST_EMIT,
        ST_SUM,
        ST_SCALE,
        ST_NORM_DIV,
        ST_NORM_OUT
    } state_t;

    // Shift enables for the two rings of state cells.
    typedef struct packed {
        logic w_en;
        logic p_en;
    } ring_ctl_t;

endpackage

/* rtl/core/hmm_scaled_forward_step_top.sv */
`timescale 1ns / 1ps
// The shared multiplier walks the matrix one entry a cycle and the serial
// divider gives one bit a cycle. One item is worked on at a time.
// Synchronous active-low reset clears the state cells and control
// registers; the tables are undefined until written.
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_top
// Scaled forward step of a multichannel HMM over a ring of state cells.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_top #(
    parameter int STATES   = hsf_pkg::DEF_STATES,
    parameter int CHANNELS = hsf_pkg::DEF_CHANNELS,
    parameter int SYMBOLS  = hsf_pkg::DEF_SYMBOLS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hsf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_command,
    input  logic [3:0]                        s_to_state,
    input  logic [3:0]                        s_from_state,
    input  logic [1:0]                        s_channel,
    input  logic [4:0]                        s_symbol,
    input  logic [31:0]                       s_table_value,
    input  logic [4:0]                        s_obs_symbol_a,
    input  logic [4:0]                        s_obs_symbol_b,
    input  logic [4:0]                        s_obs_symbol_c,
    input  logic [4:0]                        s_obs_symbol_d,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [3:0]                        m_state_index,
    output logic [31:0]                       m_alpha_value,
    output logic [63:0]                       m_scale_value,
    output logic                              m_underflow,
    output logic                              m_last
);

    localparam int PW   = hsf_pkg::PROB_W;
    localparam int IDXW = $clog2(STATES);
    localparam int KW   = $clog2(STATES + 3);
    localparam int SYMW = $clog2(SYMBOLS);
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAW  = $clog2(STATES * STATES);
    localparam int EAW  = $clog2(CHANNELS * SYMBOLS * STATES);
    localparam int CAP  = (STATES < hsf_pkg::MAX_OUT) ? STATES : hsf_pkg::MAX_OUT;

    // Index wrap tables, worked out at elaboration.
    logic [IDXW-1:0] st_mod_tab  [16];
    logic [SYMW-1:0] sym_mod_tab [32];
    logic [CHW-1:0]  ch_mod_tab  [4];

    for (genvar g = 0; g < 16; g++) begin : g_st_mod
        assign st_mod_tab[g] = IDXW'(g % STATES);
    end
    for (genvar g = 0; g < 32; g++) begin : g_sym_mod
        assign sym_mod_tab[g] = SYMW'(g % SYMBOLS);
    end
    for (genvar g = 0; g < 4; g++) begin : g_ch_mod
        assign ch_mod_tab[g] = CHW'(g % CHANNELS);
    end

    // Configuration registers.
    logic [4:0] num_states_reg;
    logic [2:0] active_channels_reg;
    logic [4:0] n_eff;
    logic [2:0] nc_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_states_reg      <= 5'd16;
            active_channels_reg <= 3'd1;
        end else if (cfg_valid) begin
            if (cfg_index == hsf_pkg::REG_NUM_STATES) begin
                num_states_reg <= cfg_data[4:0];
            end else if (cfg_index == hsf_pkg::REG_ACTIVE_CHANNELS) begin
                active_channels_reg <= cfg_data[2:0];
            end
        end
    end

    always_comb begin
        if (num_states_reg == 5'd0) begin
            n_eff = 5'd1;
        end else if (int'(num_states_reg) > CAP) begin
            n_eff = 5'(CAP);
        end else begin
            n_eff = num_states_reg;
        end
        if (active_channels_reg == 3'd0) begin
            nc_eff = 3'd1;
        end else if (int'(active_channels_reg) > CHANNELS) begin
            nc_eff = 3'(CHANNELS);
        end else begin
            nc_eff = active_channels_reg;
        end
    end

    // Control registers.
    hsf_pkg::state_t state_reg, state_next;
    logic [IDXW-1:0] i_reg, i_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [CHW-1:0]  c_reg, c_next;
    logic            m1_reg, m1_next;
    logic            under_reg, under_next;
    logic            m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [63:0]              prod_reg, prod_next;
    logic [PW-1:0]            pd_reg, pd_next;
    logic [hsf_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic [hsf_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [63:0]              scale_reg, scale_next;
    logic [PW-1:0]            alpha_reg, alpha_next;
    logic [SYMW-1:0]          sym_reg [CHANNELS];
    logic [3:0]               out_index_reg;
    logic [31:0]              out_alpha_reg;
    logic [63:0]              out_scale_reg;
    logic                     out_under_reg;
    logic                     out_last_reg;
    logic                     out_load;

    // Tables.
    logic [PW-1:0] tmem [STATES*STATES];
    logic [PW-1:0] emem [CHANNELS*SYMBOLS*STATES];
    logic [PW-1:0] imem [STATES];
    logic [PW-1:0] t_q, e_q, i_q;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [PW-1:0]  tv;
    logic           accept;

    assign accept = s_valid && s_ready;
    assign tv     = (s_table_value > hsf_pkg::ONE_Q31) ? hsf_pkg::ONE_Q31 : s_table_value;

    assign t_waddr = TAW'(st_mod_tab[s_to_state]) * TAW'(STATES)
                   + TAW'(st_mod_tab[s_from_state]);
    assign e_waddr = (EAW'(ch_mod_tab[s_channel]) * EAW'(SYMBOLS)
                   + EAW'(sym_mod_tab[s_symbol])) * EAW'(STATES)
                   + EAW'(st_mod_tab[s_to_state]);
    assign t_raddr = TAW'(i_reg) * TAW'(STATES) + TAW'(k_reg[IDXW-1:0]);
    assign e_raddr = (EAW'(c_reg) * EAW'(SYMBOLS) + EAW'(sym_reg[c_reg])) * EAW'(STATES)
                   + EAW'(i_reg);

    always_ff @(posedge aclk) begin
        if (accept && s_command == hsf_pkg::CMD_WR_TRANS) begin
            tmem[t_waddr] <= tv;
        end
        t_q <= tmem[t_raddr];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_command == hsf_pkg::CMD_WR_EMIT) begin
            emem[e_waddr] <= tv;
        end
        e_q <= emem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_command == hsf_pkg::CMD_WR_INIT) begin
            imem[st_mod_tab[s_to_state]] <= tv;
        end
        i_q <= imem[i_reg];
    end

    // Observed symbols, wrapped and held for the whole step.
    logic [4:0] obs_in [4];
    assign obs_in[0] = s_obs_symbol_a;
    assign obs_in[1] = s_obs_symbol_b;
    assign obs_in[2] = s_obs_symbol_c;
    assign obs_in[3] = s_obs_symbol_d;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_sym
        always_ff @(posedge aclk) begin
            if (accept) begin
                sym_reg[c] <= sym_mod_tab[obs_in[c]];
            end
        end
    end

    // Ring of state cells; cell 0 is the head, new values enter at the tail.
    hsf_pkg::ring_ctl_t ring_ctl;
    logic [PW-1:0] w_q [STATES];
    logic [PW-1:0] p_q [STATES];
    logic [PW-1:0] w_tail, p_tail;
    logic [PW-1:0] w_head, p_head;

    assign w_head = w_q[0];
    assign p_head = p_q[0];

    for (genvar s = 0; s < STATES; s++) begin : g_cell
        logic [PW-1:0] w_in, p_in;
        if (s == STATES - 1) begin : g_tail
            assign w_in = w_tail;
            assign p_in = p_tail;
        end else begin : g_link
            assign w_in = w_q[s+1];
            assign p_in = p_q[s+1];
        end
        hsf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ring_ctl),
            .w_in    (w_in),
            .p_in    (p_in),
            .w_q     (w_q[s]),
            .p_q     (p_q[s])
        );
    end

    // Shared divider.
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_quot;

    hsf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Shared multiplier.
    logic [PW-1:0] mul_a;
    logic [63:0]   mul_p;
    assign mul_a = (state_reg == hsf_pkg::ST_TRANS) ? t_q : e_q;
    assign mul_p = 64'(mul_a) * 64'(pd_reg);

    // Sequencing conditions.
    logic i_act, i_last, c_last, out_free;
    assign i_act    = int'(i_reg) < int'(n_eff);
    assign i_last   = int'(i_reg) == STATES - 1;
    assign c_last   = int'(c_reg) == int'(nc_eff) - 1;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == hsf_pkg::ST_IDLE;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hsf_pkg::ST_IDLE: begin
                if (accept && s_command == hsf_pkg::CMD_OBS_FIRST) begin
                    state_next = hsf_pkg::ST_INIT;
                end else if (accept && s_command == hsf_pkg::CMD_OBS_NEXT) begin
                    state_next = hsf_pkg::ST_TRANS;
                end
            end
            hsf_pkg::ST_INIT: begin
                if (k_reg == KW'(1) && i_last) begin
                    state_next = hsf_pkg::ST_EMIT;
                end
            end
            hsf_pkg::ST_TRANS: begin
                if (int'(k_reg) == STATES + 2 && i_last) begin
                    state_next = hsf_pkg::ST_EMIT;
                end
            end
            hsf_pkg::ST_EMIT: begin
                if (k_reg == KW'(2) && i_last && c_last) begin
                    state_next = hsf_pkg::ST_SUM;
                end
            end
            hsf_pkg::ST_SUM: begin
                if (int'(k_reg) == STATES - 1) begin
                    state_next = hsf_pkg::ST_SCALE;
                end
            end
            hsf_pkg::ST_SCALE: begin
                if ((k_reg == '0 && sum_reg == '0) || (k_reg == KW'(1) && div_done)) begin
                    state_next = hsf_pkg::ST_NORM_DIV;
                end
            end
            hsf_pkg::ST_NORM_DIV: begin
                if (k_reg == '0 && !i_act) begin
                    if (i_last) begin
                        state_next = hsf_pkg::ST_IDLE;
                    end
                end else if (k_reg == '0 && under_reg) begin
                    state_next = hsf_pkg::ST_NORM_OUT;
                end else if (k_reg == KW'(1) && div_done) begin
                    state_next = hsf_pkg::ST_NORM_OUT;
                end
            end
            hsf_pkg::ST_NORM_OUT: begin
                if (out_free) begin
                    state_next = i_last ? hsf_pkg::ST_IDLE : hsf_pkg::ST_NORM_DIV;
                end
            end
            default: state_next = hsf_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and next values.
    always_comb begin
        i_next       = i_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        m1_next      = 1'b0;
        under_next   = under_reg;
        pd_next      = pd_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        scale_next   = scale_reg;
        alpha_next   = alpha_reg;
        prod_next    = m1_reg ? mul_p : '0;
        ring_ctl     = '0;
        w_tail       = w_head;
        p_tail       = p_head;
        div_start    = 1'b0;
        div_dividend = {1'b0, w_head, 31'b0};
        out_load     = 1'b0;
        case (state_reg)
            hsf_pkg::ST_IDLE: begin
                i_next = '0;
                k_next = '0;
                c_next = '0;
            end
            hsf_pkg::ST_INIT: begin
                if (k_reg == '0) begin
                    k_next = KW'(1);
                end else begin
                    ring_ctl.w_en = 1'b1;
                    w_tail        = i_act ? i_q : '0;
                    k_next        = '0;
                    i_next        = i_last ? '0 : i_reg + 1'b1;
                end
            end
            hsf_pkg::ST_TRANS: begin
                if (int'(k_reg) < STATES) begin
                    // Issue T[i][j]; the previous alpha ring turns one place.
                    m1_next       = (int'(k_reg) < int'(n_eff)) && i_act;
                    pd_next       = p_head;
                    ring_ctl.p_en = 1'b1;
                end
                if (k_reg == '0) begin
                    acc_next = '0;
                end else if (k_reg >= KW'(2) && int'(k_reg) <= STATES + 1) begin
                    acc_next = acc_reg + hsf_pkg::SUM_W'(prod_reg[63:31]);
                end
                if (int'(k_reg) == STATES + 2) begin
                    ring_ctl.w_en = 1'b1;
                    w_tail        = (acc_reg[hsf_pkg::SUM_W-1:PW] != '0) ? '1
                                  : acc_reg[PW-1:0];
                    k_next        = '0;
                    i_next        = i_last ? '0 : i_reg + 1'b1;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            hsf_pkg::ST_EMIT: begin
                if (k_reg == '0) begin
                    pd_next = w_head;
                    m1_next = i_act;
                    k_next  = KW'(1);
                end else if (k_reg == KW'(1)) begin
                    k_next = KW'(2);
                end else begin
                    ring_ctl.w_en = 1'b1;
                    w_tail        = prod_reg[62:31];
                    k_next        = '0;
                    if (i_last) begin
                        i_next = '0;
                        c_next = c_last ? '0 : c_reg + 1'b1;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            hsf_pkg::ST_SUM: begin
                ring_ctl.w_en = 1'b1;
                sum_next      = (k_reg == '0) ? hsf_pkg::SUM_W'(w_head)
                              : sum_reg + hsf_pkg::SUM_W'(w_head);
                k_next        = (int'(k_reg) == STATES - 1) ? '0 : k_reg + 1'b1;
            end
            hsf_pkg::ST_SCALE: begin
                div_dividend = {1'b1, 63'b0};
                if (k_reg == '0) begin
                    if (sum_reg == '0) begin
                        scale_next = '1;
                        under_next = 1'b1;
                        i_next     = '0;
                    end else begin
                        div_start = 1'b1;
                        k_next    = KW'(1);
                    end
                end else if (div_done) begin
                    scale_next = div_quot;
                    under_next = 1'b0;
                    k_next     = '0;
                    i_next     = '0;
                end
            end
            hsf_pkg::ST_NORM_DIV: begin
                if (k_reg == '0) begin
                    if (!i_act) begin
                        // Inactive states leave a cleared previous alpha.
                        ring_ctl.w_en = 1'b1;
                        ring_ctl.p_en = 1'b1;
                        p_tail        = '0;
                        i_next        = i_last ? '0 : i_reg + 1'b1;
                    end else if (under_reg) begin
                        alpha_next = '0;
                    end else begin
                        div_start = 1'b1;
                        k_next    = KW'(1);
                    end
                end else if (div_done) begin
                    alpha_next = div_quot[PW-1:0];
                    k_next     = '0;
                end
            end
            hsf_pkg::ST_NORM_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    ring_ctl.w_en = 1'b1;
                    ring_ctl.p_en = 1'b1;
                    p_tail        = alpha_reg;
                    i_next        = i_last ? '0 : i_reg + 1'b1;
                end
            end
            default: begin
                i_next = '0;
                k_next = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hsf_pkg::ST_IDLE;
            i_reg       <= '0;
            k_reg       <= '0;
            c_reg       <= '0;
            m1_reg      <= 1'b0;
            under_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            c_reg       <= c_next;
            m1_reg      <= m1_next;
            under_reg   <= under_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        pd_reg    <= pd_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        scale_reg <= scale_next;
        alpha_reg <= alpha_next;
        if (out_load) begin
            out_index_reg <= 4'(i_reg);
            out_alpha_reg <= alpha_reg;
            out_scale_reg <= scale_reg;
            out_under_reg <= under_reg;
            out_last_reg  <= int'(i_reg) == int'(n_eff) - 1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_state_index = out_index_reg;
    assign m_alpha_value = out_alpha_reg;
    assign m_scale_value = out_scale_reg;
    assign m_underflow   = out_under_reg;
    assign m_last        = out_last_reg;

    // A zero sum gives zero alphas.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_underflow |-> m_alpha_value == '0)
        else $error("underflow result with nonzero alpha");

    // Normalized alphas never exceed one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_alpha_value <= hsf_pkg::ONE_Q31)
        else $error("alpha above one");

    // The last flag marks the last active state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> int'(m_state_index) == int'(n_eff) - 1)
        else $error("last flag on wrong state");

    // The divider is never restarted while it works.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

/* rtl/core/hsf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_cell
// One state cell: holds a working value and a previous alpha, and takes
// each from its neighbor when its ring shifts.
// ----------------------------------------------------------------------------
module hsf_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hsf_pkg::ring_ctl_t            ctl,
    input  logic [hsf_pkg::PROB_W-1:0]    w_in,
    input  logic [hsf_pkg::PROB_W-1:0]    p_in,
    output logic [hsf_pkg::PROB_W-1:0]    w_q,
    output logic [hsf_pkg::PROB_W-1:0]    p_q
);

    logic [hsf_pkg::PROB_W-1:0] w_reg, w_next;
    logic [hsf_pkg::PROB_W-1:0] p_reg, p_next;

    always_comb begin
        w_next = ctl.w_en ? w_in : w_reg;
        p_next = ctl.p_en ? p_in : p_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= '0;
            p_reg <= '0;
        end else begin
            w_reg <= w_next;
            p_reg <= p_next;
        end
    end

    assign w_q = w_reg;
    assign p_q = p_reg;

endmodule

/* rtl/core/hsf_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_divider
// Restoring divider, 64-bit dividend by sum-width divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module hsf_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [hsf_pkg::WIDE_W-1:0]    dividend,
    input  logic [hsf_pkg::SUM_W-1:0]     divisor,
    output logic                          busy,
    output logic                          done,
    output logic [hsf_pkg::WIDE_W-1:0]    quotient
);

    localparam int CW = $clog2(hsf_pkg::WIDE_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CW-1:0]               cnt_reg;
    logic [hsf_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [hsf_pkg::SUM_W-1:0]   div_reg;
    logic [hsf_pkg::WIDE_W-1:0]  dvd_reg, dvd_next;
    logic [hsf_pkg::SUM_W:0]     trial;
    logic                        ge;

    always_comb begin
        trial    = {rem_reg, dvd_reg[hsf_pkg::WIDE_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? hsf_pkg::SUM_W'(trial - {1'b0, div_reg})
                      : trial[hsf_pkg::SUM_W-1:0];
        dvd_next = {dvd_reg[hsf_pkg::WIDE_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(hsf_pkg::WIDE_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= divisor;
            dvd_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
